@@ design/rriia_pkg.sv @@
// Shared codes for the round robin instance-ID allocator.
package rriia_pkg;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  localparam int TID_W = 8;
  localparam int IID_W = 5;
  localparam int STATUS_W = 2;

endpackage

@@ design/rriia_req_if.sv @@
// Request channel: command, target and instance ID with a valid/ready handshake.
interface rriia_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [rriia_pkg::TID_W-1:0]   tid;
  logic [rriia_pkg::IID_W-1:0]   iid;

  modport source (output valid, command, tid, iid, input ready);
  modport sink   (input valid, command, tid, iid, output ready);
endinterface

@@ design/rriia_rsp_if.sv @@
// Response channel: status and granted ID with a valid/ready handshake.
interface rriia_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rriia_pkg::STATUS_W-1:0] status;
  logic [rriia_pkg::IID_W-1:0]    granted_id;

  modport source (output valid, status, granted_id, input ready);
  modport sink   (input valid, status, granted_id, output ready);
endinterface

@@ design/round_robin_instance_id_allocator.sv @@
// Per-target round robin instance-ID allocator with one state memory.
//
// A word on req asks either to allocate an instance ID for target tid or to
// free iid for that target. Each request gives exactly one word on rsp with a
// status (ok, busy, rejected) and the granted ID on a successful allocate.
// Each target's reservation map and last-granted ID live in one synchronous
// memory entry. A request reads the entry on the accepting edge; the compute
// state then runs the round robin search, writes the entry back on success
// and loads the response register. The block takes no new request until
// the single read-modify-write of the target's memory entry is done.
// The response register parts the two channels: a new request is accepted
// while a response waits. If the receiver stalls and the response register is
// still full when the next result is ready, the block holds in its compute
// state until the word is taken. After the synchronous reset every target
// reads as all IDs free with last ID zero; per-target valid flags give this
// at once, so there is no clearing pass.
module round_robin_instance_id_allocator #(
  parameter int NUM_TARGETS = 256,
  parameter int NUM_IDS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  rriia_req_if.sink   req,
  rriia_rsp_if.source rsp
);

  localparam int TW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int LW = $clog2(NUM_IDS);
  localparam int MW = NUM_IDS + LW;

  typedef enum logic [0:0] {
    S_IDLE,
    S_CALC
  } state_t;

  state_t state;

  logic [MW-1:0] mem [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] vld;

  logic [MW-1:0] rd_data;
  logic          vld_q;
  logic          cmd_q;
  logic          in_range_q;
  logic [TW-1:0] addr_q;
  logic [rriia_pkg::IID_W-1:0] iid_q;

  logic                           out_valid;
  logic [rriia_pkg::STATUS_W-1:0] out_status;
  logic [rriia_pkg::IID_W-1:0]    out_gid;

  logic [NUM_IDS-1:0] entry_map;
  logic [LW-1:0]      entry_last;
  logic [NUM_IDS-1:0] free_v;
  logic [NUM_IDS-1:0] hi_mask;
  logic [NUM_IDS-1:0] cand;
  logic               found;
  int                 pick;
  logic               last_match;
  logic               proceed;
  logic               in_acc;
  logic               wr_en;
  logic [MW-1:0]      wr_data;
  rriia_pkg::status_t status_next;
  logic [rriia_pkg::IID_W-1:0] gid_next;

  assign in_acc  = req.valid && req.ready;
  assign proceed = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.granted_id = out_gid;

  // Search for the first free ID after the last one, wrapping below it.
  always_comb begin
    entry_map  = vld_q ? rd_data[MW-1:LW] : '0;
    entry_last = vld_q ? rd_data[LW-1:0] : '0;
    free_v = ~entry_map;
    free_v[entry_last] = 1'b0;
    for (int i = 0; i < NUM_IDS; i++) begin
      hi_mask[i] = (i > int'(entry_last));
    end
    cand = ((free_v & hi_mask) != '0) ? (free_v & hi_mask) : free_v;
    found = (free_v != '0);
    pick = 0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = i;
      end
    end
    last_match = (int'(entry_last) == int'(iid_q));

    wr_en    = 1'b0;
    wr_data  = {entry_map, entry_last};
    gid_next = '0;
    if (cmd_q == rriia_pkg::CMD_ALLOC) begin
      if (in_range_q && found) begin
        status_next = rriia_pkg::ST_OK;
        gid_next    = rriia_pkg::IID_W'(pick);
        wr_en       = (state == S_CALC) && proceed;
        wr_data     = {entry_map | (NUM_IDS'(1) << pick), LW'(pick)};
      end else begin
        status_next = rriia_pkg::ST_BUSY;
      end
    end else begin
      if (in_range_q && last_match) begin
        status_next = rriia_pkg::ST_OK;
        wr_en       = (state == S_CALC) && proceed;
        wr_data     = {entry_map & ~(NUM_IDS'(1) << entry_last), entry_last};
      end else begin
        status_next = rriia_pkg::ST_REJECT;
      end
    end
  end

  // State memory: read on acceptance, written back when a successful request leaves the compute state.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= mem[req.tid[TW-1:0]];
    end
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vld_q      <= vld[req.tid[TW-1:0]];
      cmd_q      <= req.command;
      iid_q      <= req.iid;
      addr_q     <= req.tid[TW-1:0];
      in_range_q <= (32'(req.tid) < 32'(NUM_TARGETS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      out_status <= '0;
      out_gid    <= '0;
    end else begin
      if (state == S_CALC && proceed) begin
        out_valid  <= 1'b1;
        out_status <= status_next;
        out_gid    <= gid_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (proceed) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_calc_no_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && !out_valid) |=> (state == S_IDLE))
    else $error("compute state held with an empty response register");

  a_rsp_after_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_CALC))
    else $error("response appeared without a compute cycle");

  a_gid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != rriia_pkg::ST_OK) |-> (out_gid == '0))
    else $error("nonzero granted ID on a failed request");

  a_write_proceeds: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == S_IDLE && out_valid))
    else $error("memory written without delivering a response");

endmodule
